### hw/rtl/obc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obc_pkg: shared types and constants
// Sizes, payload structs and controller states of the box clustering block.
// ----------------------------------------------------------------------------
package obc_pkg;
  localparam int MAX_BOXES  = 32;
  localparam int COORD_BITS = 32;
  localparam int CW         = (COORD_BITS < 32) ? COORD_BITS : 32;
  localparam int IDX_W      = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int CNT_W      = $clog2(MAX_BOXES + 1);

  typedef logic signed [CW-1:0] coord_t;
  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    coord_t lx, ly, lz, hx, hy, hz;
  } box_t;

  typedef struct packed {
    logic signed [31:0] min_x;
    logic signed [31:0] min_y;
    logic signed [31:0] min_z;
    logic signed [31:0] max_x;
    logic signed [31:0] max_y;
    logic signed [31:0] max_z;
    logic               last_box;
  } in_item_t;

  typedef struct packed {
    logic [4:0]         source_index;
    logic [4:0]         root_index;
    logic signed [31:0] group_min_x;
    logic signed [31:0] group_min_y;
    logic signed [31:0] group_min_z;
    logic signed [31:0] group_max_x;
    logic signed [31:0] group_max_y;
    logic signed [31:0] group_max_z;
    logic               overflowed;
    logic               last_result;
  } out_item_t;

  // Memory port bundle between controller and store.
  typedef struct packed {
    logic   bwe;
    idx_t   bwaddr;
    box_t   bwdata;
    idx_t   braddr_a;
    idx_t   braddr_b;
    logic   pwe;
    idx_t   pwaddr;
    idx_t   pwdata;
    idx_t   praddr;
  } mem_req_t;

  typedef enum logic [3:0] {
    ST_LOAD, ST_INIT, ST_PASS_I, ST_RD_I, ST_CHK_J, ST_RD_J, ST_CMP,
    ST_PASS_END, ST_E_RD, ST_E_WALK, ST_E_BND, ST_E_OUT
  } state_t;

  function automatic coord_t fit(input logic [31:0] v);
    fit = coord_t'(v[CW-1:0]);
  endfunction

  function automatic logic [31:0] widen(input coord_t v);
    widen = 32'(signed'(v));
  endfunction
endpackage

### hw/rtl/overlapping_box_clustering.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// overlapping_box_clustering: merge overlapping 3D boxes into groups
// Loads boxes into memory, runs merge passes until stable, then emits one
// result per stored box with its group root and the group bounds.
// ----------------------------------------------------------------------------
//  channel | direction | payload     | transaction
//  in      | input     | in_item_t   | one box, last_box ends the set
//  out     | output    | out_item_t  | one box result, in load order
//
// Loading accepts a box whenever in is valid; in is ready every cycle in
// that phase. After the last box, each merge pass visits every root i and,
// for each j, reads j's link and bounds, then links j to i if j is another
// root that overlaps; passes repeat until none merges. Emitting walks each
// box's parent chain one link read per step, plus a bounds read. in is not
// ready from the last box until the final result transaction. A stalled
// out holds the state machine in place. Reset clears the box count, drop
// flag, output valid and state; the memories are not cleared since only
// loaded entries are ever used.
// ----------------------------------------------------------------------------
module overlapping_box_clustering import obc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);
  state_t state, state_next;
  cnt_t   box_count, box_count_next;
  logic   drop_flag, drop_flag_next;
  logic   merged, merged_next;
  idx_t   ii, ii_next;        // absorber index
  idx_t   jj, jj_next;        // candidate index / emit source
  idx_t   rr, rr_next;        // walk cursor
  cnt_t   steps, steps_next;  // walk step count
  box_t   abox, abox_next;    // absorber bounds held in registers
  out_item_t ores, ores_next;
  logic   ovalid, ovalid_next;

  mem_req_t req;
  box_t     rd_a, rd_b;
  idx_t     prd;

  obc_store u_store (
    .clk      (clk),
    .req      (req),
    .brdata_a (rd_a),
    .brdata_b (rd_b),
    .prdata   (prd)
  );

  box_t inbox;
  always_comb begin
    inbox.lx = fit(in_data.min_x);
    inbox.ly = fit(in_data.min_y);
    inbox.lz = fit(in_data.min_z);
    inbox.hx = fit(in_data.max_x);
    inbox.hy = fit(in_data.max_y);
    inbox.hz = fit(in_data.max_z);
  end

  logic overlap;
  always_comb begin
    overlap = !(abox.lx > rd_b.hx || rd_b.lx > abox.hx ||
                abox.ly > rd_b.hy || rd_b.ly > abox.hy ||
                abox.lz > rd_b.hz || rd_b.lz > abox.hz);
  end

  logic   last_i, last_j;
  assign last_i = (cnt_t'(ii) + 1'b1 == box_count);
  assign last_j = (cnt_t'(jj) + 1'b1 == box_count);

  assign in_ready  = (state == ST_LOAD);
  assign out_valid = ovalid;
  assign out_data  = ores;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      box_count <= '0;
      drop_flag <= 1'b0;
      ovalid    <= 1'b0;
    end else begin
      state     <= state_next;
      box_count <= box_count_next;
      drop_flag <= drop_flag_next;
      ovalid    <= ovalid_next;
    end
  end

  always_ff @(posedge clk) begin
    merged <= merged_next;
    ii     <= ii_next;
    jj     <= jj_next;
    rr     <= rr_next;
    steps  <= steps_next;
    abox   <= abox_next;
    ores   <= ores_next;
  end

  always_comb begin
    state_next     = state;
    box_count_next = box_count;
    drop_flag_next = drop_flag;
    merged_next    = merged;
    ii_next        = ii;
    jj_next        = jj;
    rr_next        = rr;
    steps_next     = steps;
    abox_next      = abox;
    ores_next      = ores;
    ovalid_next    = ovalid;
    req            = '0;
    req.bwaddr     = ii;
    req.bwdata     = abox;
    req.braddr_a   = ii;
    req.braddr_b   = jj;
    req.pwaddr     = jj;
    req.pwdata     = ii;
    req.praddr     = jj;
    case (state)
      ST_LOAD: begin
        if (in_valid) begin
          if (box_count < cnt_t'(MAX_BOXES)) begin
            req.bwe        = 1'b1;
            req.bwaddr     = idx_t'(box_count);
            req.bwdata     = inbox;
            req.pwe        = 1'b1;
            req.pwaddr     = idx_t'(box_count);
            req.pwdata     = idx_t'(box_count);
            box_count_next = box_count + 1'b1;
          end else begin
            drop_flag_next = 1'b1;
          end
          if (in_data.last_box) begin
            ii_next     = '0;
            merged_next = 1'b0;
            state_next  = ST_PASS_I;
          end
        end
      end
      ST_PASS_I: begin
        // Handles an empty set too: go straight to the wrap-up.
        if (box_count == '0) begin
          state_next = ST_PASS_END;
        end else begin
          req.praddr = ii;
          state_next = ST_INIT;
        end
      end
      ST_INIT: begin
        // Link of ii is on prd; read its bounds if it is a root.
        if (prd == ii) begin
          state_next = ST_RD_I;
        end else if (last_i) begin
          state_next = ST_PASS_END;
        end else begin
          ii_next    = ii + 1'b1;
          state_next = ST_PASS_I;
        end
      end
      ST_RD_I: begin
        state_next = ST_CHK_J;
        jj_next    = '0;
      end
      ST_CHK_J: begin
        if (jj == '0) begin
          abox_next = rd_a;
        end
        req.praddr = jj;
        req.braddr_b = jj;
        state_next = ST_RD_J;
      end
      ST_RD_J: begin
        state_next = ST_CMP;
        if (jj == '0 && prd == jj && jj != ii) begin
          // abox loaded this cycle boundary; nothing extra.
        end
      end
      ST_CMP: begin
        // jj's link is on prd and its bounds on rd_b, both registered reads.
        if (prd == jj && jj != ii && overlap) begin
          req.pwe   = 1'b1;
          merged_next = 1'b1;
          abox_next.lx = (abox.lx < rd_b.lx) ? abox.lx : rd_b.lx;
          abox_next.ly = (abox.ly < rd_b.ly) ? abox.ly : rd_b.ly;
          abox_next.lz = (abox.lz < rd_b.lz) ? abox.lz : rd_b.lz;
          abox_next.hx = (abox.hx > rd_b.hx) ? abox.hx : rd_b.hx;
          abox_next.hy = (abox.hy > rd_b.hy) ? abox.hy : rd_b.hy;
          abox_next.hz = (abox.hz > rd_b.hz) ? abox.hz : rd_b.hz;
        end
        if (last_j) begin
          // Absorber bounds go back to memory once per row.
          state_next = ST_RD_I;
          if (last_i) begin
            state_next = ST_PASS_END;
          end else begin
            state_next = ST_PASS_I;
          end
          ii_next = ii + 1'b1;
        end else begin
          jj_next    = jj + 1'b1;
          state_next = ST_CHK_J;
        end
        if (last_j) begin
          req.bwe    = 1'b1;
          req.bwaddr = ii;
          req.bwdata = abox_next;
        end
      end
      ST_PASS_END: begin
        if (merged) begin
          merged_next = 1'b0;
          ii_next     = '0;
          state_next  = ST_PASS_I;
        end else if (box_count == '0) begin
          drop_flag_next = 1'b0;
          state_next     = ST_LOAD;
        end else begin
          jj_next    = '0;
          rr_next    = '0;
          steps_next = '0;
          req.praddr = '0;
          state_next = ST_E_WALK;
        end
      end
      ST_E_RD: begin
        req.praddr = rr;
        state_next = ST_E_WALK;
      end
      ST_E_WALK: begin
        // prd is the link of rr; follow it until a root, an out-of-range link or the step limit.
        if (prd == rr || cnt_t'(prd) >= box_count || steps == box_count) begin
          req.braddr_a = rr;
          state_next   = ST_E_BND;
        end else begin
          rr_next    = prd;
          steps_next = steps + 1'b1;
          state_next = ST_E_RD;
        end
      end
      ST_E_BND: begin
        // Keep the root's bounds on the read port for the output stage.
        req.braddr_a = rr;
        state_next   = ST_E_OUT;
      end
      ST_E_OUT: begin
        if (!ovalid) begin
          ores_next.source_index = 5'(jj);
          ores_next.root_index   = 5'(rr);
          ores_next.group_min_x  = widen(rd_a.lx);
          ores_next.group_min_y  = widen(rd_a.ly);
          ores_next.group_min_z  = widen(rd_a.lz);
          ores_next.group_max_x  = widen(rd_a.hx);
          ores_next.group_max_y  = widen(rd_a.hy);
          ores_next.group_max_z  = widen(rd_a.hz);
          ores_next.overflowed   = drop_flag;
          ores_next.last_result  = last_j;
          ovalid_next            = 1'b1;
        end else if (out_ready) begin
          ovalid_next = 1'b0;
          if (ores.last_result) begin
            box_count_next = '0;
            drop_flag_next = 1'b0;
            state_next     = ST_LOAD;
          end else begin
            jj_next    = jj + 1'b1;
            rr_next    = jj + 1'b1;
            steps_next = '0;
            state_next = ST_E_RD;
          end
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  a_out_only_emit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> state == ST_E_OUT)
    else $error("result shown outside emit phase");
  a_no_load_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input ready while emitting");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    box_count <= cnt_t'(MAX_BOXES))
    else $error("box count beyond capacity");
endmodule

### hw/rtl/obc_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obc_store: box bound and parent link memories
// Bound memory with two registered read ports; link memory with one.
// ----------------------------------------------------------------------------
module obc_store import obc_pkg::*; (
  input  logic     clk,
  input  mem_req_t req,
  output box_t     brdata_a,
  output box_t     brdata_b,
  output idx_t     prdata
);
  box_t bmem [MAX_BOXES];
  idx_t pmem [MAX_BOXES];

  always_ff @(posedge clk) begin
    if (req.bwe) begin
      bmem[req.bwaddr] <= req.bwdata;
    end
    brdata_a <= bmem[req.braddr_a];
    brdata_b <= bmem[req.braddr_b];
  end

  always_ff @(posedge clk) begin
    if (req.pwe) begin
      pmem[req.pwaddr] <= req.pwdata;
    end
    prdata <= pmem[req.praddr];
  end
endmodule
